// File: hw/rtl/sonar_range_to_world_point_unit_defines.svh
// assertion macros shared by the checker
`ifndef SONAR_RANGE_TO_WORLD_POINT_UNIT_DEFINES_SVH
`define SONAR_RANGE_TO_WORLD_POINT_UNIT_DEFINES_SVH

// property checked at every rising edge outside reset
`define SRWP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("srwp check failed");

// implication checked at every rising edge outside reset
`define SRWP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srwp implication failed");

`endif

// File: hw/rtl/srwp_pkg.sv
// ----------------------------------------------------------------------------
// srwp_pkg
// types, constants and helpers for the sonar range to world point unit
// ----------------------------------------------------------------------------
package srwp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int LATENCY      = CORDIC_STEPS + 7;
  localparam int PW           = 72;

  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

  localparam logic signed [31:0] ATAN [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
  };

  typedef enum logic [2:0] {
    REG_FRONT_X   = 3'd0,
    REG_FRONT_Y   = 3'd1,
    REG_FRONT_YAW = 3'd2,
    REG_BACK_X    = 3'd3,
    REG_BACK_Y    = 3'd4,
    REG_BACK_YAW  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic               [1:0]  quad;
    logic signed        [32:0] x;
    logic signed        [32:0] y;
    logic signed        [31:0] z;
  } lane_t;

  typedef struct packed {
    logic                      sel;
    logic               [30:0] len;
    logic signed        [31:0] px;
    logic signed        [31:0] py;
    logic signed        [31:0] pz;
    logic signed        [31:0] mx;
    logic signed        [31:0] my;
  } item_t;

  typedef struct packed {
    logic signed [33:0] c;
    logic signed [33:0] s;
  } trig_t;

  function automatic lane_t lane_init(input logic [15:0] ang);
    lane_t l;
    l.quad = ang[15:14];
    l.x    = CORDIC_START;
    l.y    = '0;
    l.z    = signed'({2'b00, ang[13:0], 16'h0000});
    return l;
  endfunction

  // quadrant fold back after the cordic
  function automatic trig_t lane_out(input lane_t l);
    trig_t t;
    case (l.quad)
      2'd0:    begin t.c = 34'(l.x);  t.s = 34'(l.y);  end
      2'd1:    begin t.c = -34'(l.y); t.s = 34'(l.x);  end
      2'd2:    begin t.c = -34'(l.x); t.s = -34'(l.y); end
      default: begin t.c = 34'(l.y);  t.s = -34'(l.x); end
    endcase
    return t;
  endfunction

  // round half up then drop 30 fraction bits
  function automatic logic signed [37:0] rnd30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = (p + (PW'(1) <<< 29)) >>> 30;
    return q[37:0];
  endfunction

endpackage

// File: hw/rtl/sonar_range_to_world_point_unit.sv
// ----------------------------------------------------------------------------
// sonar_range_to_world_point_unit
// sonar echo to world point: mount yaw/offset, zyx euler rotation, pose add
// ----------------------------------------------------------------------------
// Takes one reading in every cycle (busy stays low) and raises done with its
// world point once the reading has passed one input register, sixteen cordic
// iterations run as pipeline stages for the four angles side by side, then
// six multiply and round stages. The receiver cannot stall, so the pipeline
// never holds. Mount registers are read when the reading enters.
module sonar_range_to_world_point_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                sensor_select,
  input  logic        [30:0]  range_reading,
  input  logic signed [31:0]  pose_x,
  input  logic signed [31:0]  pose_y,
  input  logic signed [31:0]  pose_z,
  input  logic signed [15:0]  pose_roll,
  input  logic signed [15:0]  pose_pitch,
  input  logic signed [15:0]  pose_yaw,
  input  logic                cfg_write,
  input  logic        [2:0]   cfg_index,
  input  logic        [31:0]  cfg_data,
  output logic                done,
  output logic                sensor_tag,
  output logic signed [31:0]  world_x,
  output logic signed [31:0]  world_y,
  output logic signed [31:0]  world_z
);
  import srwp_pkg::*;

  logic signed [31:0] front_x, front_y, back_x, back_y;
  logic        [15:0] front_yaw, back_yaw;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_x <= '0; front_y <= '0; front_yaw <= '0;
      back_x  <= '0; back_y  <= '0; back_yaw  <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRONT_X:   front_x   <= cfg_data;
        REG_FRONT_Y:   front_y   <= cfg_data;
        REG_FRONT_YAW: front_yaw <= cfg_data[15:0];
        REG_BACK_X:    back_x    <= cfg_data;
        REG_BACK_Y:    back_y    <= cfg_data;
        REG_BACK_YAW:  back_yaw  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // lanes: 0 mount yaw, 1 roll, 2 pitch, 3 yaw
  logic  vld  [CORDIC_STEPS+1];
  item_t item [CORDIC_STEPS+1];
  lane_t lane [CORDIC_STEPS+1][4];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= start;
    item[0].sel <= sensor_select;
    item[0].len <= range_reading;
    item[0].px  <= pose_x;
    item[0].py  <= pose_y;
    item[0].pz  <= pose_z;
    item[0].mx  <= sensor_select ? back_x : front_x;
    item[0].my  <= sensor_select ? back_y : front_y;
    lane[0][0]  <= lane_init(sensor_select ? back_yaw : front_yaw);
    lane[0][1]  <= lane_init(pose_roll);
    lane[0][2]  <= lane_init(pose_pitch);
    lane[0][3]  <= lane_init(pose_yaw);
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else     vld[i+1] <= vld[i];
      item[i+1] <= item[i];
    end
    for (genvar k = 0; k < 4; k++) begin : g_lane
      always_ff @(posedge clk) begin
        lane[i+1][k].quad <= lane[i][k].quad;
        if (!lane[i][k].z[31]) begin
          lane[i+1][k].x <= lane[i][k].x - (lane[i][k].y >>> i);
          lane[i+1][k].y <= lane[i][k].y + (lane[i][k].x >>> i);
          lane[i+1][k].z <= lane[i][k].z - ATAN[i];
        end else begin
          lane[i+1][k].x <= lane[i][k].x + (lane[i][k].y >>> i);
          lane[i+1][k].y <= lane[i][k].y - (lane[i][k].x >>> i);
          lane[i+1][k].z <= lane[i][k].z + ATAN[i];
        end
      end
    end
  end

  trig_t tm, tr, tp, ty;
  assign tm = lane_out(lane[CORDIC_STEPS][0]);
  assign tr = lane_out(lane[CORDIC_STEPS][1]);
  assign tp = lane_out(lane[CORDIC_STEPS][2]);
  assign ty = lane_out(lane[CORDIC_STEPS][3]);

  logic [5:0] v;  // valid per back-end stage

  // stage a: first products
  item_t              ia;
  trig_t              ra, ya;
  logic signed [33:0] spa;
  logic signed [PW-1:0] pbx, pby, pspsr, p00, p10, p21;
  always_ff @(posedge clk) begin
    ia    <= item[CORDIC_STEPS];
    ra    <= tr;
    ya    <= ty;
    spa   <= tp.s;
    pbx   <= signed'({1'b0, item[CORDIC_STEPS].len}) * tm.c;
    pby   <= signed'({1'b0, item[CORDIC_STEPS].len}) * tm.s;
    pspsr <= tp.s * tr.s;
    p00   <= ty.c * tp.c;
    p10   <= ty.s * tp.c;
    p21   <= tp.c * tr.s;
  end

  // stage b: vehicle-frame point, rounded entries
  logic                sb;
  logic signed [31:0]  pxb, pyb, pzb, bxb, byb;
  logic signed [37:0]  spsr, r00b, r10b, r20b, r21b;
  trig_t               rb, yb;
  logic signed [37:0]  bxs, bys;
  assign bxs = 38'(ia.mx) + rnd30(pbx);
  assign bys = 38'(ia.my) + rnd30(pby);
  always_ff @(posedge clk) begin
    sb   <= ia.sel;
    pxb  <= ia.px; pyb <= ia.py; pzb <= ia.pz;
    bxb  <= bxs[31:0];
    byb  <= bys[31:0];
    spsr <= rnd30(pspsr);
    r00b <= rnd30(p00);
    r10b <= rnd30(p10);
    r20b <= -38'(spa);
    r21b <= rnd30(p21);
    rb   <= ra;
    yb   <= ya;
  end

  // stage c: products for the middle column
  logic                sc;
  logic signed [31:0]  pxc, pyc, pzc, bxc, byc;
  logic signed [37:0]  r00c, r10c, r20c, r21c;
  logic signed [PW-1:0] q0, q1, q2, q3;
  always_ff @(posedge clk) begin
    sc <= sb;
    pxc <= pxb; pyc <= pyb; pzc <= pzb; bxc <= bxb; byc <= byb;
    r00c <= r00b; r10c <= r10b; r20c <= r20b; r21c <= r21b;
    q0 <= yb.c * spsr;
    q1 <= yb.s * rb.c;
    q2 <= yb.s * spsr;
    q3 <= yb.c * rb.c;
  end

  // stage d: middle column
  logic                sd;
  logic signed [31:0]  pxd, pyd, pzd, bxd, byd;
  logic signed [37:0]  r00d, r10d, r20d, r21d, r01d, r11d;
  always_ff @(posedge clk) begin
    sd <= sc;
    pxd <= pxc; pyd <= pyc; pzd <= pzc; bxd <= bxc; byd <= byc;
    r00d <= r00c; r10d <= r10c; r20d <= r20c; r21d <= r21c;
    r01d <= rnd30(q0) - rnd30(q1);
    r11d <= rnd30(q2) + rnd30(q3);
  end

  // stage e: rotation products
  logic                se;
  logic signed [31:0]  pxe, pye, pze;
  logic signed [PW-1:0] m00, m01, m10, m11, m20, m21;
  always_ff @(posedge clk) begin
    se <= sd;
    pxe <= pxd; pye <= pyd; pze <= pzd;
    m00 <= r00d * bxd; m01 <= r01d * byd;
    m10 <= r10d * bxd; m11 <= r11d * byd;
    m20 <= r20d * bxd; m21 <= r21d * byd;
  end

  // stage f: pose add, wraps at 32 bits
  logic signed [39:0] wx, wy, wz;
  assign wx = 40'(pxe) + 40'(rnd30(m00)) + 40'(rnd30(m01));
  assign wy = 40'(pye) + 40'(rnd30(m10)) + 40'(rnd30(m11));
  assign wz = 40'(pze) + 40'(rnd30(m20)) + 40'(rnd30(m21));
  always_ff @(posedge clk) begin
    sensor_tag <= se;
    world_x    <= wx[31:0];
    world_y    <= wy[31:0];
    world_z    <= wz[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else     v <= {v[4:0], vld[CORDIC_STEPS]};
  end
  assign done = v[5];

endmodule

// File: hw/rtl/srwp_checker.sv
// ----------------------------------------------------------------------------
// srwp_checker
// port-level checks of the sonar range to world point unit
// ----------------------------------------------------------------------------
`include "sonar_range_to_world_point_unit_defines.svh"

module srwp_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                sensor_select,
  input logic                done,
  input logic                sensor_tag
);
  import srwp_pkg::*;

  `SRWP_ASSERT(a_never_busy, clk, rst, !busy)
  `SRWP_ASSERT_IMP(a_done_has_start, clk, rst, done, $past(start && !busy, LATENCY))
  `SRWP_ASSERT_IMP(a_start_gives_done, clk, rst, start && !busy, ##LATENCY done)
  `SRWP_ASSERT_IMP(a_tag_follows, clk, rst, done, sensor_tag == $past(sensor_select, LATENCY))

endmodule

bind sonar_range_to_world_point_unit srwp_checker u_srwp_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .sensor_select (sensor_select),
  .done          (done),
  .sensor_tag    (sensor_tag)
);

// File: bench/tb_sonar_range_to_world_point_unit.sv
// ----------------------------------------------------------------------------
// tb_sonar_range_to_world_point_unit
// self-checking bench for the sonar range to world point unit
// ----------------------------------------------------------------------------
// Drives a short table of directed readings, then phases of random readings
// under several mount settings. Each accepted reading not carrying its own
// expected point is run through a fixed-point cordic/rotation predictor; every
// done strobe is checked field by field against the oldest predicted world point.
module tb_sonar_range_to_world_point_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import srwp_pkg::*;

  localparam int        STEPS      = 16;
  localparam longint    GAIN_START = 652032874;
  localparam int        DRAIN      = 40;
  localparam int        STALL_MAX  = 2000;
  localparam int        PEND_DEPTH = 64;
  localparam int        N_DIRECTED = 13;
  localparam logic[2:0] BAD_IDX_LO = 3'd6;
  localparam logic[2:0] BAD_IDX_HI = 3'd7;

  localparam longint ATAN_TAB [STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861
  };

  typedef struct {
    logic        sel;
    logic [30:0] len;
    logic [31:0] px, py, pz;
    logic [15:0] roll, pitch, yaw;
  } reading_t;

  typedef struct {
    logic        tag;
    logic [31:0] wx, wy, wz;
  } point_t;

  typedef struct {
    reading_t rd;
    bit       typed;
    point_t   pt;
  } row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               sensor_select;
  logic        [30:0] range_reading;
  logic signed [31:0] pose_x, pose_y, pose_z;
  logic signed [15:0] pose_roll, pose_pitch, pose_yaw;
  logic               cfg_write;
  logic        [2:0]  cfg_index;
  logic        [31:0] cfg_data;
  logic               done;
  logic               sensor_tag;
  logic signed [31:0] world_x, world_y, world_z;

  sonar_range_to_world_point_unit dut (.*);

  // mount settings as the unit should hold them, indexed by sensor
  logic [31:0] mnt_x [2];
  logic [31:0] mnt_y [2];
  logic [15:0] mnt_yaw [2];

  // predicted points in transfer order, ring with free-running counts
  point_t pend_buf [PEND_DEPTH];
  int     pend_wr;
  int     pend_rd;
  int     errors;
  int     quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sx32(longint v);
    return longint'($signed(v[31:0]));
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic void cordic_sincos(logic [15:0] ang, output longint c,
                                        output longint s);
    longint x, y, z, dx, dy;
    x = GAIN_START;
    y = 0;
    z = longint'(ang[13:0]) <<< 16;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    case (ang[15:14])
      2'd0:    begin c = x;  s = y;  end
      2'd1:    begin c = -y; s = x;  end
      2'd2:    begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
  endfunction

  function automatic point_t world_point(reading_t r);
    point_t p;
    longint cm, sm, cr, sr, cp, sp, cy, sy, bx, by, spsr;
    longint r00, r10, r20, r01, r11, r21;
    cordic_sincos(mnt_yaw[r.sel], cm, sm);
    bx = sx32(sx32(mnt_x[r.sel]) + mul_q30(longint'(r.len), cm));
    by = sx32(sx32(mnt_y[r.sel]) + mul_q30(longint'(r.len), sm));
    cordic_sincos(r.roll, cr, sr);
    cordic_sincos(r.pitch, cp, sp);
    cordic_sincos(r.yaw, cy, sy);
    spsr = mul_q30(sp, sr);
    r00 = mul_q30(cy, cp);
    r10 = mul_q30(sy, cp);
    r20 = -sp;
    r01 = mul_q30(cy, spsr) - mul_q30(sy, cr);
    r11 = mul_q30(sy, spsr) + mul_q30(cy, cr);
    r21 = mul_q30(cp, sr);
    p.tag = r.sel;
    p.wx  = 32'(sx32(r.px) + mul_q30(r00, bx) + mul_q30(r01, by));
    p.wy  = 32'(sx32(r.py) + mul_q30(r10, bx) + mul_q30(r11, by));
    p.wz  = 32'(sx32(r.pz) + mul_q30(r20, bx) + mul_q30(r21, by));
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // called at a rising edge; returns at a rising edge
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FRONT_X:   mnt_x[0]   = val;
      REG_FRONT_Y:   mnt_y[0]   = val;
      REG_FRONT_YAW: mnt_yaw[0] = val[15:0];
      REG_BACK_X:    mnt_x[1]   = val;
      REG_BACK_Y:    mnt_y[1]   = val;
      REG_BACK_YAW:  mnt_yaw[1] = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mounts(logic [31:0] fx, fy, logic [15:0] fyaw,
                            logic [31:0] bkx, bky, logic [15:0] byaw);
    write_reg(REG_FRONT_X, fx);
    write_reg(REG_FRONT_Y, fy);
    write_reg(REG_FRONT_YAW, {16'hffff, fyaw});
    write_reg(REG_BACK_X, bkx);
    write_reg(REG_BACK_Y, bky);
    write_reg(REG_BACK_YAW, {16'h0000, byaw});
    // out-of-range indexes must leave every mount alone
    write_reg(BAD_IDX_LO, $urandom);
    write_reg(BAD_IDX_HI, $urandom);
  endtask

  task automatic send_reading(reading_t r, int gap, bit typed, point_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    sensor_select <= r.sel;
    range_reading <= r.len;
    pose_x        <= r.px;
    pose_y        <= r.py;
    pose_z        <= r.pz;
    pose_roll     <= r.roll;
    pose_pitch    <= r.pitch;
    pose_yaw      <= r.yaw;
    do @(posedge clk); while (busy);
    if (typed) pend_buf[pend_wr % PEND_DEPTH] = want;
    else       pend_buf[pend_wr % PEND_DEPTH] = world_point(r);
    pend_wr++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic reading_t rand_reading();
    reading_t r;
    r.sel = 1'($urandom);
    // mostly modest ranges, sometimes the full field
    r.len   = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h00ff_ffff));
    r.px    = $urandom;
    r.py    = $urandom;
    r.pz    = $urandom;
    r.roll  = 16'($urandom);
    r.pitch = 16'($urandom);
    r.yaw   = 16'($urandom);
    return r;
  endfunction

  function automatic row_t mk_row(logic sel, logic [30:0] len, logic [31:0] px, py, pz,
                                  logic [15:0] ro, pi, ya, bit typed);
    row_t w;
    w.rd    = '{sel, len, px, py, pz, ro, pi, ya};
    w.typed = typed;
    // with zero mounts and zero range the point is the pose itself
    w.pt    = '{sel, px, py, pz};
    return w;
  endfunction

  row_t directed [N_DIRECTED];

  initial begin
    reading_t r;
    point_t   none;
    int       gap_hi;

    errors  = 0;
    pend_wr = 0;
    pend_rd = 0;
    rst           <= 1'b1;
    start         <= 1'b0;
    sensor_select <= 1'b0;
    range_reading <= '0;
    pose_x        <= '0;
    pose_y        <= '0;
    pose_z        <= '0;
    pose_roll     <= '0;
    pose_pitch    <= '0;
    pose_yaw      <= '0;
    cfg_write     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    none          = '{1'b0, '0, '0, '0};
    for (int k = 0; k < 2; k++) begin
      mnt_x[k] = '0; mnt_y[k] = '0; mnt_yaw[k] = '0;
    end

    directed[0]  = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 1);
    directed[1]  = mk_row(1, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                          16'h7fff, 16'h8000, 16'hffff, 1);
    directed[2]  = mk_row(0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000,
                          16'h8000, 16'h7fff, 16'h0001, 1);
    directed[3]  = mk_row(0, 31'h7fffffff, 0, 0, 0, 0, 0, 0, 0);
    directed[4]  = mk_row(1, 31'h7fffffff, 0, 0, 0, 0, 0, 0, 0);
    directed[5]  = mk_row(0, 31'h00010000, 0, 0, 0, 0, 0, 16'h4000, 0);
    directed[6]  = mk_row(0, 31'h00010000, 0, 0, 0, 0, 0, 16'h8000, 0);
    directed[7]  = mk_row(1, 31'h00010000, 0, 0, 0, 0, 0, 16'hc000, 0);
    directed[8]  = mk_row(0, 31'h00010000, 0, 0, 0, 0, 16'h4000, 0, 0);
    directed[9]  = mk_row(1, 31'h00010000, 0, 0, 0, 16'h4000, 16'h2000, 0, 0);
    directed[10] = mk_row(0, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 16'h2000, 16'h2000, 16'h2000, 0);
    directed[11] = mk_row(1, 31'h7fffffff, 32'h80000000, 32'h80000000,
                          32'h80000000, 16'hffff, 16'hffff, 16'hffff, 0);
    directed[12] = mk_row(0, 31'h55555555, 32'haaaaaaaa, 32'h55555555,
                          32'haaaaaaaa, 16'h5555, 16'haaaa, 16'h5555, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k])
      send_reading(directed[k].rd, k % 3, directed[k].typed, directed[k].pt);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_mounts(32'h7fffffff, 32'h80000000, 16'h7fff,
                      32'h80000000, 32'h7fffffff, 16'h8000);
        1: set_mounts(32'h80000000, 32'h7fffffff, 16'hffff,
                      32'h7fffffff, 32'h80000000, 16'h0000);
        2: set_mounts(32'h00008000, 32'hffff0000, 16'h4000,
                      32'hfffe0000, 32'h00030000, 16'hc000);
        default: set_mounts($urandom, $urandom, 16'($urandom),
                            $urandom, $urandom, 16'($urandom));
      endcase
      // some phases run back to back with no gaps at all
      gap_hi = (ph % 3 == 1) ? 0 : 6;
      for (int k = 0; k < 75; k++) begin
        r = rand_reading();
        send_reading(r, $urandom_range(0, gap_hi), 1'b0, none);
      end
      drain();
    end

    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // results are accepted at the edge that ends their strobe cycle
  always @(posedge clk) begin
    point_t want;
    if (!rst && done) begin
      if (pend_wr == pend_rd) begin
        report_mismatch("unexpected done", 32'(done), 32'd0);
      end else begin
        want = pend_buf[pend_rd % PEND_DEPTH];
        pend_rd++;
        if (sensor_tag !== want.tag) report_mismatch("sensor_tag", 32'(sensor_tag), 32'(want.tag));
        if (world_x !== want.wx) report_mismatch("world_x", world_x, want.wx);
        if (world_y !== want.wy) report_mismatch("world_y", world_y, want.wy);
        if (world_z !== want.wz) report_mismatch("world_z", world_z, want.wz);
      end
    end
  end

  // no transfer in either direction for too long means a hang
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

// File: sonar_range_to_world_point_unit.f
+incdir+hw/rtl
hw/rtl/srwp_pkg.sv
hw/rtl/sonar_range_to_world_point_unit.sv
hw/rtl/srwp_checker.sv
bench/tb_sonar_range_to_world_point_unit.sv
